### hdl/kot_pkg.sv
package kot_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int DEPTH_DEF         = 16;
  localparam int CONTEXT_WIDTH_DEF = 64;
  localparam int KEY_WIDTH_DEF     = 16;

  // Port widths and the widest storage the parameters allow
  localparam int KIND_W    = 3;
  localparam int IN_KEY_W  = 16;
  localparam int SLOT_IN_W = 4;
  localparam int CTX_MAX_W = 64;
  localparam int KEY_MAX_W = 32;
  localparam int OCC_W     = 5;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Operation codes on the kind field
  localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PEEK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FREE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WRITE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TICK  = 3'd5;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_PEEK,
    OP_FREE,
    OP_READ,
    OP_WRITE,
    OP_TICK,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [KEY_MAX_W-1:0] key;
    logic [SLOT_IN_W-1:0] sidx;
    logic [CTX_MAX_W-1:0] ctx;
  } item_t;

endpackage

### hdl/kot_ram.sv
module kot_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/kot_front.sv
module kot_front #(
  parameter int CONTEXT_WIDTH = kot_pkg::CONTEXT_WIDTH_DEF,
  parameter int KEY_WIDTH     = kot_pkg::KEY_WIDTH_DEF
) (
  input  logic                          start,
  output logic                          busy,
  input  logic [kot_pkg::KIND_W-1:0]    in_kind,
  input  logic [kot_pkg::IN_KEY_W-1:0]  in_lookup_key,
  input  logic [kot_pkg::SLOT_IN_W-1:0] in_slot_index,
  input  logic [kot_pkg::CTX_MAX_W-1:0] in_context_in,
  input  logic                          q_full,
  output logic                          push,
  output kot_pkg::item_t                push_item
);

  localparam logic [63:0] KEY_MASK64 = (64'd1 << KEY_WIDTH) - 64'd1;
  localparam logic [kot_pkg::KEY_MAX_W-1:0] KEY_MASK = KEY_MASK64[kot_pkg::KEY_MAX_W-1:0];
  localparam logic [kot_pkg::CTX_MAX_W-1:0] CTX_MASK =
    {kot_pkg::CTX_MAX_W{1'b1}} >> (kot_pkg::CTX_MAX_W - CONTEXT_WIDTH);

  assign busy = q_full;
  assign push = start & ~q_full;

  always_comb begin
    case (in_kind)
      kot_pkg::KIND_ALLOC: push_item.op = kot_pkg::OP_ALLOC;
      kot_pkg::KIND_PEEK:  push_item.op = kot_pkg::OP_PEEK;
      kot_pkg::KIND_FREE:  push_item.op = kot_pkg::OP_FREE;
      kot_pkg::KIND_READ:  push_item.op = kot_pkg::OP_READ;
      kot_pkg::KIND_WRITE: push_item.op = kot_pkg::OP_WRITE;
      kot_pkg::KIND_TICK:  push_item.op = kot_pkg::OP_TICK;
      default:             push_item.op = kot_pkg::OP_NONE;
    endcase
    // drop key and context bits the table does not keep
    push_item.key  = kot_pkg::KEY_MAX_W'(in_lookup_key) & KEY_MASK;
    push_item.sidx = in_slot_index;
    push_item.ctx  = in_context_in & CTX_MASK;
  end

endmodule

### hdl/kot_queue.sv
module kot_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  kot_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output kot_pkg::item_t head
);

  kot_pkg::item_t              q_r [kot_pkg::QDEPTH];
  logic [kot_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [kot_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [kot_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        do_pop;

  assign full      = (cnt_r == kot_pkg::QCNT_W'(kot_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = q_r[rd_ptr_r];
  assign do_pop    = pop & not_empty;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + kot_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + kot_pkg::QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + kot_pkg::QCNT_W'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - kot_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### hdl/kot_back.sv
module kot_back #(
  parameter int DEPTH         = kot_pkg::DEPTH_DEF,
  parameter int CONTEXT_WIDTH = kot_pkg::CONTEXT_WIDTH_DEF,
  parameter int KEY_WIDTH     = kot_pkg::KEY_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_vld,
  input  kot_pkg::item_t                item,
  output logic                          item_pop,
  output logic                          out_strobe,
  output logic                          out_ok,
  output logic [kot_pkg::SLOT_IN_W-1:0] out_slot_out,
  output logic [kot_pkg::CTX_MAX_W-1:0] out_context_out,
  output logic [kot_pkg::OCC_W-1:0]     out_occupancy,
  output logic                          out_is_full
);

  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // table control
  logic [DEPTH-1:0]     valid_r, valid_nxt;
  logic [DEPTH-1:0]     pend_r, pend_nxt;
  logic [SLOT_W-1:0]    ptr_r, ptr_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     pcnt_r, pcnt_nxt;
  // payload: keys and age matrix (age_r[j][i] set means slot j is older than slot i)
  logic [KEY_WIDTH-1:0] key_r [DEPTH];
  logic [DEPTH-1:0]     age_r [DEPTH];
  // result stage
  logic                          res_vld_r, res_vld_nxt;
  logic                          res_ok_r, res_ok_nxt;
  logic [kot_pkg::SLOT_IN_W-1:0] res_slot_r, res_slot_nxt;
  logic                          res_ram_r, res_ram_nxt;

  logic [DEPTH-1:0]         live, match, oldest, free_v, hi_v, idx_sel;
  logic                     tgt_live, found, any_free, any_hi;
  logic [SLOT_W-1:0]        found_idx, pick_hi, pick_lo, pick, sidx_w;
  logic [KEY_WIDTH-1:0]     key_m;
  logic                     alloc_go, key_we, ram_we;
  logic [SLOT_W-1:0]        ram_waddr, ram_raddr;
  logic [CONTEXT_WIDTH-1:0] ram_rdata;

  assign item_pop = item_vld;
  assign key_m    = item.key[KEY_WIDTH-1:0];
  assign sidx_w   = SLOT_W'(item.sidx);

  // classify slots in parallel
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      live[i]    = valid_r[i] & ~pend_r[i];
      match[i]   = live[i] && (key_r[i] == key_m);
      free_v[i]  = ~valid_r[i];
      hi_v[i]    = free_v[i] && (i >= int'(ptr_r));
      idx_sel[i] = (32'(item.sidx) == i);
    end
    for (int i = 0; i < DEPTH; i++) begin
      oldest[i] = match[i];
      for (int j = 0; j < DEPTH; j++) begin
        if (match[j] && age_r[j][i]) begin
          oldest[i] = 1'b0;
        end
      end
    end
    tgt_live = |(idx_sel & live);
    found    = |oldest;
    any_free = |free_v;
    any_hi   = |hi_v;
    found_idx = '0;
    pick_hi   = '0;
    pick_lo   = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (oldest[i]) found_idx = SLOT_W'(i);
      if (hi_v[i])   pick_hi   = SLOT_W'(i);
      if (free_v[i]) pick_lo   = SLOT_W'(i);
    end
    pick = any_hi ? pick_hi : pick_lo;
  end

  always_comb begin
    valid_nxt    = valid_r;
    pend_nxt     = pend_r;
    ptr_nxt      = ptr_r;
    cnt_nxt      = cnt_r;
    pcnt_nxt     = pcnt_r;
    res_vld_nxt  = item_vld;
    res_ok_nxt   = 1'b0;
    res_slot_nxt = '0;
    res_ram_nxt  = 1'b0;
    alloc_go     = 1'b0;
    key_we       = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = sidx_w;
    ram_raddr    = sidx_w;
    if (item_vld) begin
      case (item.op)
        kot_pkg::OP_ALLOC: begin
          if (any_free) begin
            alloc_go        = 1'b1;
            key_we          = 1'b1;
            ram_we          = 1'b1;
            ram_waddr       = pick;
            valid_nxt[pick] = 1'b1;
            pend_nxt[pick]  = 1'b0;
            ptr_nxt         = (pick == SLOT_W'(DEPTH - 1)) ? '0 : pick + SLOT_W'(1);
            cnt_nxt         = cnt_r + CNT_W'(1);
            res_ok_nxt      = 1'b1;
            res_slot_nxt    = kot_pkg::SLOT_IN_W'(pick);
          end
        end
        kot_pkg::OP_PEEK: begin
          ram_raddr    = found_idx;
          res_ok_nxt   = found;
          res_ram_nxt  = found;
          res_slot_nxt = found ? kot_pkg::SLOT_IN_W'(found_idx) : '0;
        end
        kot_pkg::OP_FREE: begin
          if (tgt_live) begin
            pend_nxt   = pend_r | idx_sel;
            pcnt_nxt   = pcnt_r + CNT_W'(1);
            res_ok_nxt = 1'b1;
          end
        end
        kot_pkg::OP_READ: begin
          res_ok_nxt  = tgt_live;
          res_ram_nxt = tgt_live;
        end
        kot_pkg::OP_WRITE: begin
          ram_we     = tgt_live;
          res_ok_nxt = tgt_live;
        end
        kot_pkg::OP_TICK: begin
          // retire every pending slot at once
          valid_nxt  = valid_r & ~pend_r;
          pend_nxt   = '0;
          cnt_nxt    = cnt_r - pcnt_r;
          pcnt_nxt   = '0;
          res_ok_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      pend_r    <= '0;
      ptr_r     <= '0;
      cnt_r     <= '0;
      pcnt_r    <= '0;
      res_vld_r <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      pend_r    <= pend_nxt;
      ptr_r     <= ptr_nxt;
      cnt_r     <= cnt_nxt;
      pcnt_r    <= pcnt_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_ok_r   <= res_ok_nxt;
    res_slot_r <= res_slot_nxt;
    res_ram_r  <= res_ram_nxt;
    if (key_we) begin
      key_r[pick] <= key_m;
    end
    // the new slot is younger than every other slot
    if (alloc_go) begin
      for (int j = 0; j < DEPTH; j++) begin
        if (j == int'(pick)) begin
          age_r[j] <= '0;
        end else begin
          age_r[j][pick] <= 1'b1;
        end
      end
    end
  end

  kot_ram #(
    .WIDTH (CONTEXT_WIDTH),
    .DEPTH (DEPTH),
    .AW    (SLOT_W)
  ) u_ctx_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (item.ctx[CONTEXT_WIDTH-1:0]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_strobe      = res_vld_r;
  assign out_ok          = res_ok_r;
  assign out_slot_out    = res_slot_r;
  assign out_context_out = res_ram_r ? kot_pkg::CTX_MAX_W'(ram_rdata) : '0;
  assign out_occupancy   = kot_pkg::OCC_W'(cnt_r);
  assign out_is_full     = (cnt_r == CNT_W'(DEPTH));

endmodule

### hdl/keyed_outstanding_table_top.sv
// Result path: a transaction is registered into the queue at the edge that accepts
//   it, then through the table update into the result stage that drives the strobe.
// Throughput: one transaction per cycle; the back end drains the queue every cycle,
//   with a parallel slot compare and a registered context RAM read.
// Reset: synchronous, active low; the table comes up empty, no clearing pass is needed.
//   The receiver cannot stall and the queue never fills, so busy stays low.
module keyed_outstanding_table_top #(
  parameter int DEPTH         = kot_pkg::DEPTH_DEF,
  parameter int CONTEXT_WIDTH = kot_pkg::CONTEXT_WIDTH_DEF,
  parameter int KEY_WIDTH     = kot_pkg::KEY_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [kot_pkg::KIND_W-1:0]    in_kind,
  input  logic [kot_pkg::IN_KEY_W-1:0]  in_lookup_key,
  input  logic [kot_pkg::SLOT_IN_W-1:0] in_slot_index,
  input  logic [kot_pkg::CTX_MAX_W-1:0] in_context_in,
  output logic                          out_strobe,
  output logic                          out_ok,
  output logic [kot_pkg::SLOT_IN_W-1:0] out_slot_out,
  output logic [kot_pkg::CTX_MAX_W-1:0] out_context_out,
  output logic [kot_pkg::OCC_W-1:0]     out_occupancy,
  output logic                          out_is_full
);

  // Front to queue: a transaction is pushed whenever start meets a non-full queue.
  logic           push;
  kot_pkg::item_t push_item;
  logic           q_full;

  // Queue to back: the back end pops the head every cycle it is present.
  logic           q_not_empty;
  logic           q_pop;
  kot_pkg::item_t q_head;

  // Decode the kind into an operation and trim key and context to stored widths.
  kot_front #(
    .CONTEXT_WIDTH (CONTEXT_WIDTH),
    .KEY_WIDTH     (KEY_WIDTH)
  ) u_front (
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_lookup_key (in_lookup_key),
    .in_slot_index (in_slot_index),
    .in_context_in (in_context_in),
    .q_full        (q_full),
    .push          (push),
    .push_item     (push_item)
  );

  // Hold classified transactions between the front and the back end.
  kot_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Execute against the slot table: parallel key match with an age matrix picks
  // the oldest live entry, a rotating priority pick serves alloc, and a pending
  // counter lets tick settle occupancy without a population count.
  kot_back #(
    .DEPTH         (DEPTH),
    .CONTEXT_WIDTH (CONTEXT_WIDTH),
    .KEY_WIDTH     (KEY_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_vld        (q_not_empty),
    .item            (q_head),
    .item_pop        (q_pop),
    .out_strobe      (out_strobe),
    .out_ok          (out_ok),
    .out_slot_out    (out_slot_out),
    .out_context_out (out_context_out),
    .out_occupancy   (out_occupancy),
    .out_is_full     (out_is_full)
  );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

localparam int SLOTS = kot_pkg::DEPTH_DEF;

// Kind codes outside the defined operations; the table must answer ok=0 for them
localparam logic [kot_pkg::KIND_W-1:0] KIND_RSVD_LO = 3'd6;
localparam logic [kot_pkg::KIND_W-1:0] KIND_RSVD_HI = 3'd7;

typedef struct packed {
  logic                          ok;
  logic [kot_pkg::SLOT_IN_W-1:0] slot;
  logic [kot_pkg::CTX_MAX_W-1:0] ctx;
  logic [kot_pkg::OCC_W-1:0]     occ;
  logic                          full;
} table_reply_t;

class kot_scoreboard;
  // shadow copy of the slot table
  bit                            in_use[SLOTS];
  bit                            retire_mark[SLOTS];
  logic [kot_pkg::IN_KEY_W-1:0]  slot_tag[SLOTS];
  logic [63:0]                   slot_stamp[SLOTS];
  logic [kot_pkg::CTX_MAX_W-1:0] slot_ctx[SLOTS];
  int                            alloc_hint;
  logic [63:0]                   issue_counter;
  int                            used_count;

  table_reply_t expected_replies[$];

  int mismatches;
  int replies_seen;
  int op_hist[8];
  int full_refusals;
  int peek_hits;
  int full_seen;

  function new();
    for (int i = 0; i < SLOTS; i++) begin
      in_use[i]      = 0;
      retire_mark[i] = 0;
      slot_tag[i]    = '0;
      slot_stamp[i]  = '0;
      slot_ctx[i]    = '0;
    end
    alloc_hint    = 0;
    issue_counter = '0;
    used_count    = 0;
    mismatches    = 0;
    replies_seen  = 0;
    full_refusals = 0;
    peek_hits     = 0;
    full_seen     = 0;
    for (int k = 0; k < 8; k++) op_hist[k] = 0;
  endfunction

  function bit is_live(int idx);
    return in_use[idx] && !retire_mark[idx];
  endfunction

  // random live slot, or -1 when none
  function int pick_live_slot();
    int live[$];
    for (int i = 0; i < SLOTS; i++) if (is_live(i)) live.push_back(i);
    if (live.size() == 0) return -1;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  // update the shadow table for one accepted transaction and queue its reply
  function void accept_op(logic [kot_pkg::KIND_W-1:0] kind,
                          logic [kot_pkg::IN_KEY_W-1:0] key,
                          logic [kot_pkg::SLOT_IN_W-1:0] sidx,
                          logic [kot_pkg::CTX_MAX_W-1:0] ctx);
    table_reply_t r;
    bit           hit;
    int           best;
    int           idx;
    r = '0;
    op_hist[kind]++;
    case (kind)
      kot_pkg::KIND_ALLOC: begin
        if (used_count < SLOTS) begin
          for (int i = 0; i < SLOTS; i++) begin
            idx = (alloc_hint + i) % SLOTS;
            if (!in_use[idx]) begin
              in_use[idx]      = 1;
              retire_mark[idx] = 0;
              slot_tag[idx]    = key;
              slot_stamp[idx]  = issue_counter;
              issue_counter    = issue_counter + 64'd1;
              slot_ctx[idx]    = ctx;
              used_count++;
              alloc_hint = (idx + 1) % SLOTS;
              r.ok   = 1'b1;
              r.slot = idx[kot_pkg::SLOT_IN_W-1:0];
              break;
            end
          end
        end else begin
          full_refusals++;
        end
      end
      kot_pkg::KIND_PEEK: begin
        hit  = 0;
        best = 0;
        // strict compare keeps the lowest index on equal sequence numbers
        for (int i = 0; i < SLOTS; i++) begin
          if (is_live(i) && slot_tag[i] == key) begin
            if (!hit || slot_stamp[i] < slot_stamp[best]) begin
              hit  = 1;
              best = i;
            end
          end
        end
        if (hit) begin
          r.ok   = 1'b1;
          r.slot = best[kot_pkg::SLOT_IN_W-1:0];
          r.ctx  = slot_ctx[best];
          peek_hits++;
        end
      end
      kot_pkg::KIND_FREE: begin
        if (is_live(sidx)) begin
          retire_mark[sidx] = 1;
          r.ok = 1'b1;
        end
      end
      kot_pkg::KIND_READ: begin
        if (is_live(sidx)) begin
          r.ctx = slot_ctx[sidx];
          r.ok  = 1'b1;
        end
      end
      kot_pkg::KIND_WRITE: begin
        if (is_live(sidx)) begin
          slot_ctx[sidx] = ctx;
          r.ok = 1'b1;
        end
      end
      kot_pkg::KIND_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (in_use[i] && retire_mark[i]) begin
            in_use[i]      = 0;
            retire_mark[i] = 0;
            slot_tag[i]    = '0;
            slot_stamp[i]  = '0;
            slot_ctx[i]    = '0;
            if (used_count > 0) used_count--;
          end
        end
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.occ  = used_count[kot_pkg::OCC_W-1:0];
    r.full = (used_count == SLOTS);
    if (r.full) full_seen++;
    expected_replies.push_back(r);
  endfunction

  task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= 50)
      $display("[%0t] ERROR %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task check_reply(table_reply_t got);
    table_reply_t want;
    replies_seen++;
    if (expected_replies.size() == 0) begin
      report_mismatch("result with no transaction outstanding", '0, '0);
      return;
    end
    want = expected_replies.pop_front();
    if (got.ok !== want.ok) report_mismatch("ok", got.ok, want.ok);
    if (got.slot !== want.slot) report_mismatch("slot_out", got.slot, want.slot);
    if (got.ctx !== want.ctx) report_mismatch("context_out", got.ctx, want.ctx);
    if (got.occ !== want.occ) report_mismatch("occupancy", got.occ, want.occ);
    if (got.full !== want.full) report_mismatch("is_full", got.full, want.full);
  endtask
endclass

module testbench;

  // Generous ceiling for ~850 transactions plus drains and reset
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_OPS  = 800;
  localparam int CALM_TAIL   = 150;   // phases that start in the last 150 go out back to back
  localparam int SETTLE      = 8;     // margin after the drain to catch stray results

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [kot_pkg::KIND_W-1:0]    in_kind;
  logic [kot_pkg::IN_KEY_W-1:0]  in_lookup_key;
  logic [kot_pkg::SLOT_IN_W-1:0] in_slot_index;
  logic [kot_pkg::CTX_MAX_W-1:0] in_context_in;
  logic                          out_strobe;
  logic                          out_ok;
  logic [kot_pkg::SLOT_IN_W-1:0] out_slot_out;
  logic [kot_pkg::CTX_MAX_W-1:0] out_context_out;
  logic [kot_pkg::OCC_W-1:0]     out_occupancy;
  logic                          out_is_full;

  kot_scoreboard sb = new;
  int            cycle_count = 0;

  keyed_outstanding_table_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_lookup_key   (in_lookup_key),
    .in_slot_index   (in_slot_index),
    .in_context_in   (in_context_in),
    .out_strobe      (out_strobe),
    .out_ok          (out_ok),
    .out_slot_out    (out_slot_out),
    .out_context_out (out_context_out),
    .out_occupancy   (out_occupancy),
    .out_is_full     (out_is_full)
  );

  always #4 clk = ~clk;

  // Abort a hung run: nothing else bounds the handshake waits
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("keyed_outstanding_table_top: mismatch");
      $finish;
    end
  end

  // Sample each strobed result at the edge that ends its cycle and check it
  // against the oldest outstanding expectation.
  always @(posedge clk) begin
    table_reply_t got;
    if (rst_n === 1'b1 && out_strobe !== 1'b0) begin
      got.ok   = out_ok;
      got.slot = out_slot_out;
      got.ctx  = out_context_out;
      got.occ  = out_occupancy;
      got.full = out_is_full;
      sb.check_reply(got);
    end
  end

  // Present one transaction from the falling edge and hold it until a rising
  // edge sees busy low; record it with the scoreboard at that edge.
  task automatic send_op(logic [kot_pkg::KIND_W-1:0] kind,
                         logic [kot_pkg::IN_KEY_W-1:0] key,
                         logic [kot_pkg::SLOT_IN_W-1:0] sidx,
                         logic [kot_pkg::CTX_MAX_W-1:0] ctx);
    @(negedge clk);
    start         <= 1'b1;
    in_kind       <= kind;
    in_lookup_key <= key;
    in_slot_index <= sidx;
    in_context_in <= ctx;
    do @(posedge clk); while (busy !== 1'b0);
    sb.accept_op(kind, key, sidx, ctx);
  endtask

  // Drop start and let the clock run idle, n times over
  task automatic idle_for(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_replies.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [kot_pkg::IN_KEY_W-1:0]  key_pool[4];
    logic [kot_pkg::KIND_W-1:0]    kind;
    logic [kot_pkg::IN_KEY_W-1:0]  key;
    logic [kot_pkg::SLOT_IN_W-1:0] sidx;
    logic [kot_pkg::CTX_MAX_W-1:0] ctx;
    int                            mix;
    int                            idle_pct;
    int                            roll;
    int                            live;
    int                            c_alloc, c_peek, c_free, c_read, c_write, c_tick;

    // Drive every input to a known value before the first edge
    rst_n         = 1'b0;
    start         = 1'b0;
    in_kind       = kot_pkg::KIND_ALLOC;
    in_lookup_key = '0;
    in_slot_index = '0;
    in_context_in = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed: empty-table corners, then the special cases one by one ---
    send_op(kot_pkg::KIND_TICK, '0, '0, '0);               // tick on an empty table
    send_op(kot_pkg::KIND_PEEK, 16'hFFFF, '0, '0);         // peek miss
    send_op(kot_pkg::KIND_READ, '0, 4'd0, '0);             // read of a dead slot
    send_op(kot_pkg::KIND_FREE, '0, 4'hF, '1);             // free of a dead slot
    send_op(KIND_RSVD_LO, 16'hFFFF, 4'hF, '1);             // unknown kinds change nothing
    send_op(KIND_RSVD_HI, 16'hFFFF, 4'hF, '1);
    send_op(kot_pkg::KIND_ALLOC, 16'h0000, 4'd0, 64'h0);   // slot 0
    send_op(kot_pkg::KIND_ALLOC, 16'hFFFF, 4'hF, '1);      // slot 1, oldest with key FFFF
    send_op(kot_pkg::KIND_ALLOC, 16'h1234, 4'd0, 64'h0123_4567_89AB_CDEF);
    send_op(kot_pkg::KIND_ALLOC, 16'hFFFF, 4'd0, 64'h8000_0000_0000_0001);
    send_op(kot_pkg::KIND_PEEK, 16'hFFFF, '0, '0);         // must pick the older slot
    send_op(kot_pkg::KIND_WRITE, '0, 4'd2, '1);
    send_op(kot_pkg::KIND_READ, '0, 4'd2, '0);
    send_op(kot_pkg::KIND_FREE, '0, 4'd1, '0);
    send_op(kot_pkg::KIND_FREE, '0, 4'd1, '0);             // already pending: refused
    send_op(kot_pkg::KIND_READ, '0, 4'd1, '0);             // pending slot is not live
    send_op(kot_pkg::KIND_WRITE, '0, 4'd1, 64'hDEAD_BEEF_0000_FFFF);
    send_op(kot_pkg::KIND_PEEK, 16'hFFFF, '0, '0);         // skips the pending slot
    send_op(kot_pkg::KIND_TICK, '0, '0, '0);               // retires slot 1
    // Fill the table through the pointer wrap, then overflow it once
    repeat (13) send_op(kot_pkg::KIND_ALLOC, 16'(($urandom)), '0, {$urandom, $urandom});
    send_op(kot_pkg::KIND_ALLOC, 16'hABCD, '0, '1);        // full: refused

    // --- random: phases that lean toward filling, draining or a balanced mix ---
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    key_pool[2] = 16'hA5A5;
    key_pool[3] = 16'($urandom);
    mix      = 0;
    idle_pct = 0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 100 == 0) begin
        mix      = $urandom_range(0, 2);
        idle_pct = (n >= RANDOM_OPS - CALM_TAIL) ? 0 : 10 * $urandom_range(0, 3);
      end
      // pause once mid-run until the block has answered everything
      if (n == RANDOM_OPS / 2) wait_drained();
      if ($urandom_range(1, 100) <= idle_pct) idle_for($urandom_range(1, 3));

      // cumulative cut points out of 100; the remainder goes to unknown kinds
      case (mix)
        0: begin
          c_alloc = 50; c_peek = 65; c_free = 75; c_read = 83; c_write = 91; c_tick = 97;
        end
        1: begin
          c_alloc = 15; c_peek = 30; c_free = 60; c_read = 70; c_write = 80; c_tick = 97;
        end
        default: begin
          c_alloc = 30; c_peek = 45; c_free = 60; c_read = 72; c_write = 84; c_tick = 97;
        end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < c_alloc)      kind = kot_pkg::KIND_ALLOC;
      else if (roll < c_peek)  kind = kot_pkg::KIND_PEEK;
      else if (roll < c_free)  kind = kot_pkg::KIND_FREE;
      else if (roll < c_read)  kind = kot_pkg::KIND_READ;
      else if (roll < c_write) kind = kot_pkg::KIND_WRITE;
      else if (roll < c_tick)  kind = kot_pkg::KIND_TICK;
      else kind = kot_pkg::KIND_W'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI));

      // reuse a few keys so peeks find duplicates; sometimes any key
      if ($urandom_range(0, 9) < 7) key = key_pool[$urandom_range(0, 3)];
      else                          key = 16'($urandom);

      // aim slot operations mostly at live slots
      live = sb.pick_live_slot();
      if (live >= 0 && $urandom_range(0, 99) < 85) sidx = live[kot_pkg::SLOT_IN_W-1:0];
      else sidx = kot_pkg::SLOT_IN_W'($urandom_range(0, SLOTS - 1));

      roll = $urandom_range(0, 99);
      if (roll < 10)      ctx = '1;
      else if (roll < 15) ctx = '0;
      else                ctx = {$urandom, $urandom};

      send_op(kind, key, sidx, ctx);
    end

    // --- drain: collect every result, then watch for strays ---
    wait_drained();
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d transactions: %0d alloc (%0d refused when full), %0d peek (%0d hits),",
             sb.replies_seen, sb.op_hist[kot_pkg::KIND_ALLOC], sb.full_refusals,
             sb.op_hist[kot_pkg::KIND_PEEK], sb.peek_hits);
    $display("  %0d free, %0d read, %0d write, %0d tick, %0d unknown kind; %0d on a full table",
             sb.op_hist[kot_pkg::KIND_FREE], sb.op_hist[kot_pkg::KIND_READ],
             sb.op_hist[kot_pkg::KIND_WRITE], sb.op_hist[kot_pkg::KIND_TICK],
             sb.op_hist[KIND_RSVD_LO] + sb.op_hist[KIND_RSVD_HI], sb.full_seen);
    if (sb.mismatches == 0 && sb.expected_replies.size() == 0) begin
      $display("keyed_outstanding_table_top: match");
    end else begin
      $display("keyed_outstanding_table_top: mismatch");
    end
    $finish;
  end

endmodule
